// ===== hw/rtl/s5h_pkg.sv =====
// s5h_pkg: types and constants shared by the SOCKS5 client handshake block.
// No dependencies.
`default_nettype none
package s5h_pkg;

  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_RX_BYTE = 3'd1;
  localparam logic [2:0] KIND_TX_SLOT = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT = 3'd3;
  localparam logic [2:0] KIND_LOAD    = 3'd4;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_PROGRESS = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;
  localparam logic [1:0] ST_FAILED   = 2'd3;

  localparam logic [2:0] FAIL_NONE        = 3'd0;
  localparam logic [2:0] FAIL_VERSION     = 3'd1;
  localparam logic [2:0] FAIL_METHOD      = 3'd2;
  localparam logic [2:0] FAIL_CONNECT     = 3'd3;
  localparam logic [2:0] FAIL_ADDR_TYPE   = 3'd4;
  localparam logic [2:0] FAIL_TIMEOUT     = 3'd5;

  localparam logic [0:0] CFG_DEST_PORT   = 1'd0;
  localparam logic [0:0] CFG_NAME_LENGTH = 1'd1;

  localparam logic [7:0] SOCKS_VER     = 8'h05;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HELLO,
    PH_WAIT_METH,
    PH_REQUEST,
    PH_WAIT_REPL,
    PH_DONE,
    PH_FAILED
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] name_index;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic [2:0] fail_reason;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/s5h_name_mem.sv =====
// s5h_name_mem: domain name store, one write and one registered read port,
// with same-cycle write-to-read forwarding. Uses no package.
`default_nettype none
module s5h_name_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_q;
  logic [7:0] fwd_data;
  logic       fwd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q     <= mem[raddr];
    fwd_data <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= we && (waddr == raddr);
    end
  end

  assign rdata = fwd ? fwd_data : rd_q;

endmodule
`default_nettype wire

// ===== hw/rtl/s5h_ctrl.sv =====
// s5h_ctrl: handshake sequencer, configuration registers and per-transfer
// result. Depends on s5h_pkg; reads and writes s5h_name_mem.
`default_nettype none
module s5h_ctrl #(
  parameter int NAME_DEPTH = 256,
  parameter int AW         = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire s5h_pkg::item_t  item,
  input  wire logic            cfg_write,
  input  wire logic [0:0]      cfg_index,
  input  wire logic [15:0]     cfg_data,
  input  wire logic [7:0]      rd_data,
  output logic                 wr_en,
  output logic      [AW-1:0]   wr_addr,
  output logic      [7:0]      wr_data,
  output logic      [AW-1:0]   rd_addr,
  output s5h_pkg::result_t     result
);
  import s5h_pkg::*;

  phase_t     phase, phase_next;
  logic [8:0] tx_position, tx_position_next;
  logic [8:0] rx_count, rx_count_next;
  logic [8:0] tail_left, tail_left_next;
  logic       addr_domain, addr_domain_next;
  logic [2:0] cause, cause_next;
  logic [15:0] dest_port;
  logic [7:0]  name_length;

  logic [8:0] req_total;
  logic [8:0] tx_inc;
  logic [8:0] name_idx;
  logic [8:0] tail_dec;
  logic [7:0] req_byte;
  logic [7:0] hello_byte;

  assign req_total = 9'd7 + {1'b0, name_length};
  assign tx_inc    = tx_position + 9'd1;
  assign name_idx  = tx_position - 9'd5;
  assign tail_dec  = (tail_left != 9'd0) ? tail_left - 9'd1 : 9'd0;

  always_comb begin
    case (tx_position[1:0])
      2'd0:    hello_byte = SOCKS_VER;
      2'd1:    hello_byte = CMD_CONNECT;
      default: hello_byte = BYTE_ZERO;
    endcase
  end

  always_comb begin
    if (tx_position < 9'd4) begin
      case (tx_position[1:0])
        2'd0:    req_byte = SOCKS_VER;
        2'd1:    req_byte = CMD_CONNECT;
        2'd2:    req_byte = BYTE_ZERO;
        default: req_byte = ATYP_DOMAIN;
      endcase
    end else if (tx_position == 9'd4) begin
      req_byte = name_length;
    end else if (tx_position < req_total - 9'd2) begin
      req_byte = (name_idx < 9'(NAME_DEPTH)) ? rd_data : BYTE_ZERO;
    end else if (tx_position == req_total - 9'd2) begin
      req_byte = dest_port[15:8];
    end else begin
      req_byte = dest_port[7:0];
    end
  end

  // next state
  always_comb begin
    phase_next       = phase;
    tx_position_next = tx_position;
    rx_count_next    = rx_count;
    tail_left_next   = tail_left;
    addr_domain_next = addr_domain;
    cause_next       = cause;
    if (accept) begin
      case (item.kind)
        KIND_START: begin
          phase_next       = PH_HELLO;
          tx_position_next = 9'd0;
          rx_count_next    = 9'd0;
          tail_left_next   = 9'd0;
          addr_domain_next = 1'b0;
          cause_next       = FAIL_NONE;
        end
        KIND_RX_BYTE: begin
          if (phase == PH_WAIT_METH) begin
            if (rx_count == 9'd0) begin
              if (item.data_byte != SOCKS_VER) begin
                phase_next = PH_FAILED;
                cause_next = FAIL_VERSION;
              end else begin
                rx_count_next = 9'd1;
              end
            end else if (item.data_byte != BYTE_ZERO) begin
              phase_next = PH_FAILED;
              cause_next = FAIL_METHOD;
            end else begin
              phase_next       = PH_REQUEST;
              tx_position_next = 9'd0;
              rx_count_next    = 9'd0;
            end
          end else if (phase == PH_WAIT_REPL) begin
            if (rx_count != 9'h1FF) begin
              rx_count_next = rx_count + 9'd1;
            end
            if (rx_count == 9'd0) begin
              if (item.data_byte != SOCKS_VER) begin
                phase_next = PH_FAILED;
                cause_next = FAIL_VERSION;
              end
            end else if (rx_count == 9'd1) begin
              if (item.data_byte != BYTE_ZERO) begin
                phase_next = PH_FAILED;
                cause_next = FAIL_CONNECT;
              end
            end else if (rx_count == 9'd2) begin
              // reserved byte
            end else if (rx_count == 9'd3) begin
              addr_domain_next = (item.data_byte == ATYP_DOMAIN);
              if (item.data_byte == ATYP_IPV4) begin
                tail_left_next = 9'd6;
              end else if (item.data_byte == ATYP_IPV6) begin
                tail_left_next = 9'd18;
              end else if (item.data_byte == ATYP_DOMAIN) begin
                tail_left_next = 9'd1;
              end else begin
                phase_next = PH_FAILED;
                cause_next = FAIL_ADDR_TYPE;
              end
            end else if (rx_count == 9'd4 && addr_domain) begin
              tail_left_next = {1'b0, item.data_byte} + 9'd2;
            end else begin
              tail_left_next = tail_dec;
              if (tail_dec == 9'd0) begin
                phase_next = PH_DONE;
              end
            end
          end
        end
        KIND_TX_SLOT: begin
          if (phase == PH_HELLO) begin
            tx_position_next = tx_inc;
            if (tx_inc >= 9'd3) begin
              phase_next       = PH_WAIT_METH;
              tx_position_next = 9'd0;
              rx_count_next    = 9'd0;
            end
          end else if (phase == PH_REQUEST) begin
            tx_position_next = tx_inc;
            if (tx_inc >= req_total) begin
              phase_next       = PH_WAIT_REPL;
              tx_position_next = 9'd0;
              rx_count_next    = 9'd0;
              tail_left_next   = 9'd0;
              addr_domain_next = 1'b0;
            end
          end
        end
        KIND_TIMEOUT: begin
          if (phase == PH_HELLO || phase == PH_WAIT_METH ||
              phase == PH_REQUEST || phase == PH_WAIT_REPL) begin
            phase_next = PH_FAILED;
            cause_next = FAIL_TIMEOUT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    result = '0;
    if (item.kind == KIND_TX_SLOT && phase == PH_HELLO) begin
      result.tx_valid = 1'b1;
      result.tx_byte  = hello_byte;
    end else if (item.kind == KIND_TX_SLOT && phase == PH_REQUEST) begin
      result.tx_valid = 1'b1;
      result.tx_byte  = req_byte;
    end
    case (phase_next)
      PH_IDLE:   result.status = ST_IDLE;
      PH_DONE:   result.status = ST_COMPLETE;
      PH_FAILED: begin
        result.status      = ST_FAILED;
        result.fail_reason = cause_next;
      end
      default:   result.status = ST_PROGRESS;
    endcase
  end

  // prefetch the name byte for the position the next transfer will see
  assign rd_addr = AW'(tx_position_next - 9'd5);
  assign wr_en   = accept && (item.kind == KIND_LOAD) &&
                   ({1'b0, item.name_index} < 9'(NAME_DEPTH));
  assign wr_addr = AW'(item.name_index);
  assign wr_data = item.data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tx_position <= 9'd0;
      rx_count    <= 9'd0;
      tail_left   <= 9'd0;
      addr_domain <= 1'b0;
      cause       <= FAIL_NONE;
      dest_port   <= 16'd0;
      name_length <= 8'd0;
    end else begin
      phase       <= phase_next;
      tx_position <= tx_position_next;
      rx_count    <= rx_count_next;
      tail_left   <= tail_left_next;
      addr_domain <= addr_domain_next;
      cause       <= cause_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_DEST_PORT:   dest_port   <= cfg_data;
          CFG_NAME_LENGTH: name_length <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/s5h_out_buf.sv =====
// s5h_out_buf: two-entry result buffer (output register plus skid) between
// the sequencer and the result channel. Depends on s5h_pkg.
`default_nettype none
module s5h_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire s5h_pkg::result_t push_data,
  output logic                  can_push,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output s5h_pkg::result_t      out_data
);
  import s5h_pkg::*;

  result_t skid_data;
  logic    skid_valid;
  logic    pop;

  assign can_push = !skid_valid;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/socks5_client_handshake.sv =====
// socks5_client_handshake: top level of the SOCKS5 no-auth CONNECT client.
// Depends on s5h_pkg, s5h_name_mem, s5h_ctrl, s5h_out_buf.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------
//   input    | in_valid / in_ready   | kind, data_byte, name_index
//   result   | out_valid / out_ready | tx_valid, tx_byte, status, fail_reason
//   config   | cfg_write             | cfg_index, cfg_data
//
// One transfer per cycle while in_ready is high; each result is registered before
// it shows. The name byte for the next transmit slot is prefetched from the name
// memory's single read port while the current transfer is taken.
// Reset is synchronous and clears all control state; the name memory is not
// cleared. A stalled result channel holds up to two results before in_ready drops.
`default_nettype none
module socks5_client_handshake #(
  parameter int NAME_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  name_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             tx_valid,
  output logic      [7:0]  tx_byte,
  output logic      [1:0]  status,
  output logic      [2:0]  fail_reason,
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import s5h_pkg::*;

  localparam int AW = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;

  item_t          item;
  result_t        step_res;
  result_t        out_res;
  logic           accept;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     rd_data;

  assign item   = '{kind: kind, data_byte: data_byte, name_index: name_index};
  assign accept = in_valid && in_ready;

  s5h_name_mem #(.DEPTH(NAME_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  s5h_ctrl #(.NAME_DEPTH(NAME_DEPTH), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .result    (step_res)
  );

  s5h_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign tx_valid    = out_res.tx_valid;
  assign tx_byte     = out_res.tx_byte;
  assign status      = out_res.status;
  assign fail_reason = out_res.fail_reason;

endmodule
`default_nettype wire

// ===== hw/rtl/s5h_checker.sv =====
// s5h_checker: port-level assertions for socks5_client_handshake, bound to it.
// Depends on s5h_pkg.
`default_nettype none
module s5h_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       tx_valid,
  input wire logic [7:0] tx_byte,
  input wire logic [1:0] status,
  input wire logic [2:0] fail_reason
);
  import s5h_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_fail_has_reason: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FAILED) |-> (fail_reason != FAIL_NONE))
    else $error("failed status without reason");

  a_reason_only_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_FAILED) |-> (fail_reason == FAIL_NONE))
    else $error("reason reported without failure");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tx_valid) |-> (tx_byte == 8'd0))
    else $error("tx_byte nonzero without tx_valid");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(tx_byte) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind socks5_client_handshake s5h_checker u_s5h_checker (.*);
`default_nettype wire

// ===== tb/sv/s5h_link_monitor.sv =====
// s5h_link_monitor: watches the input, result and config ports of the SOCKS5 client
// handshake block, predicts every result and compares it field by field.
// Depends on s5h_pkg.
module s5h_link_monitor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  name_index,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        tx_valid,
  input  wire logic [7:0]  tx_byte,
  input  wire logic [1:0]  status,
  input  wire logic [2:0]  fail_reason,
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import s5h_pkg::*;

  localparam logic [7:0] HELLO_NMETHODS = 8'h01;
  localparam logic [7:0] METHOD_NO_AUTH = BYTE_ZERO;
  localparam logic [8:0] RX_COUNT_MAX   = 9'd511;
  localparam int         REPORT_MAX     = 10;

  phase_t      hs_phase;
  logic [8:0]  tx_pos;
  logic [8:0]  rx_cnt;
  logic [8:0]  tail_left;
  logic [7:0]  addr_type;
  logic [2:0]  cause;
  logic [15:0] port_cfg;
  logic [7:0]  len_cfg;
  logic [7:0]  name_bytes [0:255];
  result_t     pending_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    foreach (name_bytes[i]) name_bytes[i] = 8'h00;
  end

  function automatic logic [7:0] request_byte(input logic [8:0] pos);
    logic [8:0] name_end;
    name_end = 9'd5 + {1'b0, len_cfg};
    case (pos)
      9'd0: return SOCKS_VER;
      9'd1: return CMD_CONNECT;
      9'd2: return BYTE_ZERO;
      9'd3: return ATYP_DOMAIN;
      9'd4: return len_cfg;
      default: begin
        if (pos < name_end) return name_bytes[pos - 9'd5];
        if (pos == name_end) return port_cfg[15:8];
        return port_cfg[7:0];
      end
    endcase
  endfunction

  function automatic void fail_with(input logic [2:0] why);
    hs_phase = PH_FAILED;
    cause    = why;
  endfunction

  function automatic void take_method_byte(input logic [7:0] b);
    if (rx_cnt == 9'd0) begin
      if (b != SOCKS_VER) fail_with(FAIL_VERSION);
      else rx_cnt = 9'd1;
    end else if (b != METHOD_NO_AUTH) begin
      fail_with(FAIL_METHOD);
    end else begin
      hs_phase = PH_REQUEST;
      tx_pos   = 9'd0;
      rx_cnt   = 9'd0;
    end
  endfunction

  function automatic void take_reply_byte(input logic [7:0] b);
    logic [8:0] n;
    n = rx_cnt;
    if (rx_cnt < RX_COUNT_MAX) rx_cnt = rx_cnt + 9'd1;
    if (n == 9'd0) begin
      if (b != SOCKS_VER) fail_with(FAIL_VERSION);
    end else if (n == 9'd1) begin
      if (b != BYTE_ZERO) fail_with(FAIL_CONNECT);
    end else if (n == 9'd2) begin
      // reserved, not checked
    end else if (n == 9'd3) begin
      addr_type = b;
      if (b == ATYP_IPV4) tail_left = 9'd6;
      else if (b == ATYP_IPV6) tail_left = 9'd18;
      else if (b == ATYP_DOMAIN) tail_left = 9'd1;
      else fail_with(FAIL_ADDR_TYPE);
    end else if (n == 9'd4 && addr_type == ATYP_DOMAIN) begin
      tail_left = {1'b0, b} + 9'd2;
    end else begin
      if (tail_left != 9'd0) tail_left = tail_left - 9'd1;
      if (tail_left == 9'd0) hs_phase = PH_DONE;
    end
  endfunction

  function automatic result_t step_handshake(input item_t it);
    result_t r;
    r = '0;
    case (it.kind)
      KIND_START: begin
        hs_phase  = PH_HELLO;
        tx_pos    = 9'd0;
        rx_cnt    = 9'd0;
        tail_left = 9'd0;
        addr_type = 8'h00;
        cause     = FAIL_NONE;
      end
      KIND_RX_BYTE: begin
        if (hs_phase == PH_WAIT_METH) take_method_byte(it.data_byte);
        else if (hs_phase == PH_WAIT_REPL) take_reply_byte(it.data_byte);
      end
      KIND_TX_SLOT: begin
        if (hs_phase == PH_HELLO) begin
          r.tx_valid = 1'b1;
          case (tx_pos)
            9'd0:    r.tx_byte = SOCKS_VER;
            9'd1:    r.tx_byte = HELLO_NMETHODS;
            default: r.tx_byte = METHOD_NO_AUTH;
          endcase
          tx_pos = tx_pos + 9'd1;
          if (tx_pos >= 9'd3) begin
            hs_phase = PH_WAIT_METH;
            tx_pos   = 9'd0;
            rx_cnt   = 9'd0;
          end
        end else if (hs_phase == PH_REQUEST) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = request_byte(tx_pos);
          tx_pos     = tx_pos + 9'd1;
          if (tx_pos >= 9'd7 + {1'b0, len_cfg}) begin
            hs_phase  = PH_WAIT_REPL;
            tx_pos    = 9'd0;
            rx_cnt    = 9'd0;
            tail_left = 9'd0;
            addr_type = 8'h00;
          end
        end
      end
      KIND_TIMEOUT: begin
        if (hs_phase == PH_HELLO || hs_phase == PH_WAIT_METH ||
            hs_phase == PH_REQUEST || hs_phase == PH_WAIT_REPL) fail_with(FAIL_TIMEOUT);
      end
      KIND_LOAD: name_bytes[it.name_index] = it.data_byte;
      default: ;
    endcase
    case (hs_phase)
      PH_IDLE:   r.status = ST_IDLE;
      PH_DONE:   r.status = ST_COMPLETE;
      PH_FAILED: r.status = ST_FAILED;
      default:   r.status = ST_PROGRESS;
    endcase
    r.fail_reason = (r.status == ST_FAILED) ? cause : FAIL_NONE;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    item_t   it;
    result_t got;
    result_t want;
    if (rst) begin
      hs_phase  = PH_IDLE;
      tx_pos    = 9'd0;
      rx_cnt    = 9'd0;
      tail_left = 9'd0;
      addr_type = 8'h00;
      cause     = FAIL_NONE;
      port_cfg  = 16'h0000;
      len_cfg   = 8'h00;
      pending_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_DEST_PORT:   port_cfg = cfg_data;
          CFG_NAME_LENGTH: len_cfg  = cfg_data[7:0];
          default: ;
        endcase
      end
      // compare before taking this edge's input: results are registered, so none belongs to it
      if (out_valid && out_ready) begin
        got.tx_valid    = tx_valid;
        got.tx_byte     = tx_byte;
        got.status      = status;
        got.fail_reason = fail_reason;
        if (pending_results.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: result transfer with nothing expected: %s %0b %02h %0d %0d",
                     $time, "tx/byte/status/reason", got.tx_valid, got.tx_byte,
                     got.status, got.fail_reason);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
              got.status !== want.status || got.fail_reason !== want.fail_reason) begin
            if (mismatches < REPORT_MAX)
              $display("%0t: result mismatch: exp tx %0b %02h status %0d reason %0d,%s",
                       $time, want.tx_valid, want.tx_byte, want.status,
                       want.fail_reason,
                       $sformatf(" got tx %0b %02h status %0d reason %0d",
                                 got.tx_valid, got.tx_byte, got.status,
                                 got.fail_reason));
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        it.kind       = kind;
        it.data_byte  = data_byte;
        it.name_index = name_index;
        pending_results.push_back(step_handshake(it));
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: drives the SOCKS5 client handshake block with handshake sessions, noise
// and config changes, with random gaps on both channels; s5h_link_monitor checks.
// Depends on s5h_pkg, s5h_link_monitor and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import s5h_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int IDLE_MAX    = 12;
  localparam int ITEM_TARGET = 1200;
  localparam int CYCLE_LIMIT = 600000;
  localparam int NAME_LAST   = 254;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic [2:0]  kind       = KIND_START;
  logic [7:0]  data_byte  = 8'h00;
  logic [7:0]  name_index = 8'h00;
  logic        out_ready  = 1'b0;
  logic        cfg_write  = 1'b0;
  logic [0:0]  cfg_index  = CFG_DEST_PORT;
  logic [15:0] cfg_data   = 16'h0000;
  wire logic       in_ready;
  wire logic       out_valid;
  wire logic       tx_valid;
  wire logic [7:0] tx_byte;
  wire logic [1:0] status;
  wire logic [2:0] fail_reason;
  int mismatches;
  int outstanding;

  int   sent       = 0;
  int   stall_left = 0;
  bit   send_gaps  = 1'b1;
  bit   recv_gaps  = 1'b1;
  logic [7:0] link_len = 8'h00;

  always #(CLK_PERIOD / 2) clk = ~clk;

  socks5_client_handshake i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .data_byte(data_byte), .name_index(name_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .tx_valid(tx_valid), .tx_byte(tx_byte), .status(status), .fail_reason(fail_reason),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  s5h_link_monitor i_monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .data_byte(data_byte), .name_index(name_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .tx_valid(tx_valid), .tx_byte(tx_byte), .status(status), .fail_reason(fail_reason),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // result side: random stall after each transfer, with stretches of none
  always @(posedge clk) begin : result_sink
    int draw;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_ready) begin
      if (out_valid) begin
        draw = recv_gaps ? $urandom_range(0, IDLE_MAX) : 0;
        if ($urandom_range(0, 47) == 0) recv_gaps <= !recv_gaps;
        if (draw != 0) begin
          out_ready  <= 1'b0;
          stall_left <= draw;
        end
      end
    end else if (stall_left <= 1) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic item_t make_item(input logic [2:0] k, input logic [7:0] d,
                                      input logic [7:0] ni);
    item_t it;
    it.kind       = k;
    it.data_byte  = d;
    it.name_index = ni;
    return it;
  endfunction

  function automatic item_t rx_item(input logic [7:0] b);
    return make_item(KIND_RX_BYTE, b, rnd8());
  endfunction

  function automatic item_t slot_item();
    return make_item(KIND_TX_SLOT, rnd8(), rnd8());
  endfunction

  function automatic item_t noise_item();
    return make_item(3'($urandom_range(0, 7)), rnd8(), 8'($urandom_range(0, NAME_LAST)));
  endfunction

  task automatic push_item(input item_t it);
    int gap;
    gap = send_gaps ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= it.kind;
    data_byte  <= it.data_byte;
    name_index <= it.name_index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_link_config(input logic [15:0] port, input logic [7:0] len);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DEST_PORT;
    cfg_data  <= port;
    @(posedge clk);
    cfg_index <= CFG_NAME_LENGTH;
    cfg_data  <= {8'h00, len};
    @(posedge clk);
    cfg_write <= 1'b0;
    link_len = len;
  endtask

  // one well-formed session with random content, sometimes broken on purpose
  task automatic run_handshake();
    item_t      script [$];
    int         checks [$];
    int         pos;
    int         keep;
    int         tail;
    logic [7:0] atyp;
    logic [7:0] dlen;
    script.push_back(make_item(KIND_START, rnd8(), rnd8()));
    repeat (3) script.push_back(slot_item());
    checks.push_back(script.size());
    script.push_back(rx_item(SOCKS_VER));
    checks.push_back(script.size());
    script.push_back(rx_item(BYTE_ZERO));
    repeat (7 + int'(link_len)) script.push_back(slot_item());
    checks.push_back(script.size());
    script.push_back(rx_item(SOCKS_VER));
    checks.push_back(script.size());
    script.push_back(rx_item(BYTE_ZERO));
    script.push_back(rx_item(rnd8()));
    case ($urandom_range(0, 2))
      0: begin
        atyp = ATYP_IPV4;
        tail = 6;
      end
      1: begin
        atyp = ATYP_IPV6;
        tail = 18;
      end
      default: begin
        atyp = ATYP_DOMAIN;
        dlen = ($urandom_range(0, 24) == 0) ? 8'hFF : 8'($urandom_range(0, 6));
        tail = int'(dlen) + 2;
      end
    endcase
    checks.push_back(script.size());
    script.push_back(rx_item(atyp));
    if (atyp == ATYP_DOMAIN) script.push_back(rx_item(dlen));
    repeat (tail) script.push_back(rx_item(rnd8()));

    case ($urandom_range(0, 11))
      0: begin
        pos = checks[$urandom_range(0, checks.size() - 1)];
        script[pos].data_byte = script[pos].data_byte ^ 8'($urandom_range(1, 255));
      end
      1: script.insert($urandom_range(1, script.size()), make_item(KIND_TIMEOUT, rnd8(), rnd8()));
      2: begin
        keep = $urandom_range(1, script.size() - 1);
        while (script.size() > keep) void'(script.pop_back());
      end
      3: repeat ($urandom_range(1, 4)) script.insert($urandom_range(1, script.size()), noise_item());
      4: script.push_back(make_item(KIND_TIMEOUT, rnd8(), rnd8()));
      default: if ($urandom_range(0, 2) == 0) script.insert(1, rx_item(rnd8()));
    endcase
    repeat ($urandom_range(0, 2))
      script.push_back($urandom_range(0, 1) ? slot_item() : rx_item(rnd8()));

    send_gaps = ($urandom_range(0, 3) != 0);
    foreach (script[i]) push_item(script[i]);
  endtask

  initial begin : stimulus
    int         s;
    logic [15:0] port;
    logic [7:0]  len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: idle specials, then a clean session with an empty domain reply
    set_link_config(16'h12AB, 8'd2);
    push_item(make_item(KIND_LOAD, 8'h00, 8'd0));
    push_item(make_item(KIND_LOAD, 8'hFF, 8'd1));
    push_item(make_item(KIND_LOAD, 8'h5A, 8'(NAME_LAST)));
    push_item(slot_item());
    push_item(make_item(KIND_TIMEOUT, 8'hFF, 8'hFF));
    push_item(make_item(KIND_START, 8'h00, 8'h00));
    repeat (3) push_item(slot_item());
    push_item(rx_item(SOCKS_VER));
    push_item(rx_item(BYTE_ZERO));
    repeat (9) push_item(slot_item());
    push_item(rx_item(SOCKS_VER));
    push_item(rx_item(BYTE_ZERO));
    push_item(rx_item(8'hFF));
    push_item(rx_item(ATYP_DOMAIN));
    push_item(rx_item(8'h00));
    push_item(rx_item(8'hFF));
    push_item(rx_item(8'h00));

    // fill name entries 0 to 254 so any name length reads written entries
    for (int i = 0; i <= NAME_LAST; i++) push_item(make_item(KIND_LOAD, rnd8(), 8'(i)));

    s = 0;
    while (sent < ITEM_TARGET) begin
      if (s < 3 || $urandom_range(0, 3) == 0) begin
        drain_results();
        case (s)
          0: set_link_config(16'hFFFF, 8'd255);
          1: set_link_config(16'h0000, 8'd0);
          2: set_link_config(16'h8001, 8'd254);
          default: begin
            case ($urandom_range(0, 9))
              0:       port = 16'h0000;
              1:       port = 16'hFFFF;
              default: port = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 29))
              0:       len = 8'd255;
              1, 2:    len = 8'd0;
              default: len = 8'($urandom_range(1, 8));
            endcase
            set_link_config(port, len);
          end
        endcase
      end
      run_handshake();
      s++;
    end

    drain_results();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
